>>> sv/hac_pkg.sv
// ----------------------------------------------------------------------------
// hac_pkg
// Shared types, constants and helpers of the stepper axis homing controller.
// ----------------------------------------------------------------------------
package hac_pkg;

    // Scale of the step period computation
    localparam int unsigned DELAY_SCALE = 1334000;

    // Field and register widths
    localparam int unsigned PERIOD_W = 23;
    localparam int unsigned POS_W    = 27;
    localparam int unsigned DIV_W    = 27;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 22;
    localparam int unsigned IN_DW    = 8;
    localparam int unsigned OUT_DW   = 40;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
    localparam logic [DIV_W-1:0]    SCALE_DIVIDEND = DIV_W'(DELAY_SCALE);

    // Reciprocal of 100 for the percent scaling:
    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**30
    localparam int unsigned         RECIP_W     = 26;
    localparam int unsigned         RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0]  RECIP_100   = 26'd42949673;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MAX_SPEED      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEPS_PER_MM   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SPEED_PERCENT  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SEEK_DIRECTION = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INVERT_DIR     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_RETRACT_MM     = 3'd5;
    localparam logic [CFG_AW-1:0] REG_HOME_POS_MM    = 3'd6;
    localparam logic [CFG_AW-1:0] REG_DWELL_TICKS    = 3'd7;

    // Item kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Phase codes as seen on the result
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_SEEK    = 3'd1;
    localparam logic [2:0] CODE_DWELL1  = 3'd2;
    localparam logic [2:0] CODE_BACK    = 3'd3;
    localparam logic [2:0] CODE_DWELL2  = 3'd4;
    localparam logic [2:0] CODE_RETRACT = 3'd5;

    // Homing phase, held one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SEEK    = 6'b000010,
        PH_DWELL1  = 6'b000100,
        PH_BACK    = 6'b001000,
        PH_DWELL2  = 6'b010000,
        PH_RETRACT = 6'b100000
    } phase_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic tick;          // apply one ordinary item and load the result
        logic mul_a;         // register max_speed * steps_per_mm
        logic mul_b;         // register the product times speed_percent
        logic scale;         // register the product divided by 100
        logic div_go;        // launch the divider: scale over the divisor
        logic kind_retract;  // long item is a retract entry, not a start
        logic finish;        // apply the long item and load the result
    } hac_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic retract_entry; // a tick now would enter the retract phase
        logic div_done;      // divider quotient is ready
    } hac_status_t;

    // Saturate a quotient to the step period range
    function automatic logic [PERIOD_W-1:0] sat_period(input logic [DIV_W-1:0] q);
        logic [PERIOD_W-1:0] r;
        if (q > DIV_W'(PERIOD_MAX))
            r = PERIOD_MAX;
        else
            r = q[PERIOD_W-1:0];
        return r;
    endfunction

    // Encode the one-hot phase as its result code
    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        unique case (p)
            PH_IDLE:    c = CODE_IDLE;
            PH_SEEK:    c = CODE_SEEK;
            PH_DWELL1:  c = CODE_DWELL1;
            PH_BACK:    c = CODE_BACK;
            PH_DWELL2:  c = CODE_DWELL2;
            PH_RETRACT: c = CODE_RETRACT;
            default:    c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

>>> sv/hac_div.sv
// ----------------------------------------------------------------------------
// hac_div
// Restoring divider, one quotient bit per cycle, for the step period.
// ----------------------------------------------------------------------------
module hac_div
    import hac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    // Advance one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_W])
            begin
                rem_next  = shifted[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next  = trial[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsr_reg  <= dsr_next;
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

>>> sv/hac_datapath.sv
// ----------------------------------------------------------------------------
// hac_datapath
// Configuration registers, homing phase state, step timing and position.
// ----------------------------------------------------------------------------
module hac_datapath
    import hac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              home_switch,
    input  hac_cmd_t          cmd,
    output hac_status_t       status,
    output logic [OUT_DW-1:0] result
);

    // Configuration registers
    logic [9:0]  max_speed_reg;
    logic [9:0]  steps_per_mm_reg;
    logic [6:0]  speed_percent_reg;
    logic        seek_direction_reg;
    logic        invert_dir_reg;
    logic [7:0]  retract_mm_reg;
    logic [15:0] home_pos_mm_reg;
    logic [21:0] dwell_ticks_reg;

    // Homing state
    phase_t                      phase_reg, phase_next;
    logic [PERIOD_W-1:0]         tick_count_reg, tick_count_next;
    logic [PERIOD_W-1:0]         period_reg, period_next;
    logic signed [POS_W-1:0]     axis_reg, axis_next;
    logic signed [POS_W-1:0]     target_reg, target_next;
    logic                        dir_reg, dir_next;
    logic                        toggle_reg, toggle_next;
    logic                        done_reg, done_next;

    // Period arithmetic
    logic [19:0]               prod_a_reg;
    logic [DIV_W-1:0]          prod_reg;
    logic [DIV_W+RECIP_W-1:0]  recip_prod;
    logic [DIV_W-1:0]          pct_quot_reg;
    logic [DIV_W-1:0]          div_divisor;
    logic [DIV_W-1:0]          div_quot;
    logic                      div_done;

    logic [PERIOD_W+1:0]     period_x4;
    logic [17:0]             retract_dist;
    logic signed [15:0]      home_s;
    logic signed [10:0]      steps_s;
    logic signed [POS_W-1:0] home_steps;
    logic [PERIOD_W-1:0]     dwell_load;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg      <= 10'd100;
            steps_per_mm_reg   <= 10'd80;
            speed_percent_reg  <= 7'd20;
            seek_direction_reg <= 1'b0;
            invert_dir_reg     <= 1'b0;
            retract_mm_reg     <= 8'd5;
            home_pos_mm_reg    <= 16'd0;
            dwell_ticks_reg    <= 22'd2000000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_SPEED:      max_speed_reg      <= cfg_data[9:0];
                REG_STEPS_PER_MM:   steps_per_mm_reg   <= cfg_data[9:0];
                REG_SPEED_PERCENT:  speed_percent_reg  <= cfg_data[6:0];
                REG_SEEK_DIRECTION: seek_direction_reg <= cfg_data[0];
                REG_INVERT_DIR:     invert_dir_reg     <= cfg_data[0];
                REG_RETRACT_MM:     retract_mm_reg     <= cfg_data[7:0];
                REG_HOME_POS_MM:    home_pos_mm_reg    <= cfg_data[15:0];
                REG_DWELL_TICKS:    dwell_ticks_reg    <= cfg_data[21:0];
                default:            ;
            endcase
        end
    end

    // Divide the percent product by 100 through a reciprocal multiply
    assign recip_prod = (DIV_W+RECIP_W)'(prod_reg) * (DIV_W+RECIP_W)'(RECIP_100);

    // Build the divisor products, one multiply per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
            prod_a_reg <= 20'(max_speed_reg) * 20'(steps_per_mm_reg);
        if (cmd.mul_b)
            prod_reg <= DIV_W'(prod_a_reg) * DIV_W'(speed_percent_reg);
        if (cmd.scale)
            pct_quot_reg <= DIV_W'(recip_prod[DIV_W+RECIP_W-1:RECIP_SHIFT]);
    end

    // Select the divisor: full speed for retract, scaled seek speed for start
    assign div_divisor = cmd.kind_retract ? DIV_W'(prod_a_reg) : pct_quot_reg;

    hac_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (SCALE_DIVIDEND),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    assign period_x4    = {2'b00, period_reg} << 2;
    assign retract_dist = 18'(retract_mm_reg) * 18'(steps_per_mm_reg);
    assign home_s       = signed'(home_pos_mm_reg);
    assign steps_s      = signed'({1'b0, steps_per_mm_reg});
    assign home_steps   = POS_W'(home_s) * POS_W'(steps_s);
    assign dwell_load   = PERIOD_W'(dwell_ticks_reg);

    // Update the homing state for one item
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        axis_next       = axis_reg;
        target_next     = target_reg;
        dir_next        = dir_reg;
        toggle_next     = toggle_reg;
        done_next       = done_reg;
        if (cmd.finish)
        begin
            toggle_next = 1'b0;
            done_next   = 1'b0;
            period_next = sat_period(div_quot);
            if (cmd.kind_retract)
            begin
                axis_next   = '0;
                target_next = seek_direction_reg ? -POS_W'(retract_dist)
                                                 : POS_W'(retract_dist);
                phase_next  = PH_RETRACT;
            end
            else
            begin
                dir_next        = seek_direction_reg ^ invert_dir_reg;
                tick_count_next = '0;
                phase_next      = PH_SEEK;
            end
        end
        else if (cmd.tick)
        begin
            toggle_next = 1'b0;
            done_next   = 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_SEEK:
                begin
                    if (home_switch)
                    begin
                        dir_next        = ~dir_reg;
                        tick_count_next = dwell_load;
                        phase_next      = PH_DWELL1;
                    end
                    else if (tick_count_reg == '0)
                    begin
                        tick_count_next = period_reg;
                        toggle_next     = 1'b1;
                    end
                    else
                        tick_count_next = tick_count_reg - 1'b1;
                end
                PH_DWELL1:
                begin
                    if (tick_count_reg == '0)
                    begin
                        period_next = (period_x4 > (PERIOD_W+2)'(PERIOD_MAX)) ?
                                      PERIOD_MAX : period_x4[PERIOD_W-1:0];
                        phase_next  = PH_BACK;
                    end
                    else
                        tick_count_next = tick_count_reg - 1'b1;
                end
                PH_BACK:
                begin
                    if (!home_switch)
                    begin
                        tick_count_next = dwell_load;
                        phase_next      = PH_DWELL2;
                    end
                    else if (tick_count_reg == '0)
                    begin
                        tick_count_next = period_reg;
                        toggle_next     = 1'b1;
                    end
                    else
                        tick_count_next = tick_count_reg - 1'b1;
                end
                PH_DWELL2:
                begin
                    // the retract entry itself goes through the long path
                    tick_count_next = tick_count_reg - 1'b1;
                end
                PH_RETRACT:
                begin
                    if (axis_reg == target_reg)
                    begin
                        axis_next  = home_steps;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (tick_count_reg == '0)
                    begin
                        tick_count_next = period_reg;
                        toggle_next     = 1'b1;
                        axis_next = (axis_reg < target_reg) ? axis_reg + 1'b1
                                                            : axis_reg - 1'b1;
                    end
                    else
                        tick_count_next = tick_count_reg - 1'b1;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            period_reg     <= '0;
            axis_reg       <= '0;
            target_reg     <= '0;
            dir_reg        <= 1'b0;
            toggle_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            period_reg     <= period_next;
            axis_reg       <= axis_next;
            target_reg     <= target_next;
            dir_reg        <= dir_next;
            toggle_reg     <= toggle_next;
            done_reg       <= done_next;
        end
    end

    assign status.retract_entry = (phase_reg == PH_DWELL2) && (tick_count_reg == '0);
    assign status.div_done      = div_done;

    // Result fields, lowest first: toggle, dir, phase, busy, done, position
    assign result = {6'b0, axis_reg, done_reg, (phase_reg != PH_IDLE),
                     phase_code(phase_reg), dir_reg, toggle_reg};

endmodule

>>> sv/hac_ctrl.sv
// ----------------------------------------------------------------------------
// hac_ctrl
// Sequencer for item acceptance, period computation and result hand-off.
// ----------------------------------------------------------------------------
module hac_ctrl
    import hac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_op,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  hac_status_t status,
    output hac_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_WAIT    = 7'b0000001,
        ST_MUL_A   = 7'b0000010,
        ST_MUL_B   = 7'b0000100,
        ST_SCALE   = 7'b0001000,
        ST_DIV_GO  = 7'b0010000,
        ST_DIV_RUN = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        kind_reg, kind_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    // Take an item in the wait state while the result slot is free or draining
    assign in_ready = (state_reg == ST_WAIT) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Step through the period computation
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind_retract = kind_reg;
        unique case (state_reg)
            ST_WAIT:
            begin
                if (accept)
                begin
                    if (in_op == OP_START)
                    begin
                        kind_next  = 1'b0;
                        state_next = ST_MUL_A;
                    end
                    else if (status.retract_entry)
                    begin
                        kind_next  = 1'b1;
                        state_next = ST_MUL_A;
                    end
                    else
                        cmd.tick = 1'b1;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = kind_reg ? ST_DIV_GO : ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (status.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_WAIT;
            end
            default:
                state_next = ST_WAIT;
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb
    begin
        if (cmd.tick || cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/stepper_axis_homing_controller.sv
// ----------------------------------------------------------------------------
// stepper_axis_homing_controller
// Homing sequencer for one stepper axis: seek, dwell, backoff, dwell, retract.
// ----------------------------------------------------------------------------
// Flow: a tick item gives its result in the cycle after acceptance; one tick
// is taken per cycle while the result side keeps up. A start item runs three
// multiply stages, then one pass of the serial divider, a tick entering retract
// one multiply and one divider pass; the next item waits for that result.
// Reset: asynchronous, active low; phase idle, counters and position zero,
// configuration registers at their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stepper_axis_homing_controller
    import hac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input item
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // [0] home_switch, [7:1] zero
    input  logic              s_tuser,   // [0] op
    // result item
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // [0] step_toggle, [1] dir_level,
                                         // [4:2] phase, [5] busy_res,
                                         // [6] done_res, [33:7] position,
                                         // [39:34] zero
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data
);

    hac_cmd_t    cmd;
    hac_status_t status;

    assign cfg_ready = 1'b1;

    hac_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    hac_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .home_switch (s_tdata[0]),
        .cmd         (cmd),
        .status      (status),
        .result      (m_tdata)
    );

endmodule

>>> dv/homing_checker.sv
// ----------------------------------------------------------------------------
// homing_checker
// Watches the item, result and configuration channels of the homing
// controller, predicts every result from its own copy of the sequencer state
// and compares each result transaction field by field, oldest first.
// ----------------------------------------------------------------------------
module homing_checker
    import hac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // [0] home_switch, [7:1] zero
    input  logic              s_tuser,   // [0] op
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_DW-1:0] m_tdata,   // [0] step_toggle, [1] dir_level,
                                         // [4:2] phase, [5] busy_res,
                                         // [6] done_res, [33:7] position,
                                         // [39:34] zero
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                pending,
    output int                fail_count
);

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic             step_toggle;
        logic             dir_level;
        logic [2:0]       phase;
        logic             busy_res;
        logic             done_res;
        logic [POS_W-1:0] position;
    } homing_result_t;

    // Mirrored configuration registers
    logic [9:0]  r_max_speed;
    logic [9:0]  r_steps_per_mm;
    logic [6:0]  r_speed_percent;
    logic        r_seek_dir;
    logic        r_invert_dir;
    logic [7:0]  r_retract_mm;
    logic [15:0] r_home_mm;
    logic [21:0] r_dwell;

    // Predicted sequencer state
    logic [2:0]          hm_phase;
    logic [PERIOD_W-1:0] hm_count;
    logic [PERIOD_W-1:0] hm_period;
    int                  hm_pos;
    int                  hm_target;
    logic                hm_dir;

    homing_result_t expected_results[$];
    int             result_index;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Step period from a divisor, saturated to the counter range
    function automatic logic [PERIOD_W-1:0] period_for(input logic [63:0] divisor);
        logic [63:0] quotient;
        if (divisor == 0)
            return PERIOD_MAX;
        quotient = 64'(DELAY_SCALE) / divisor;
        return (quotient > 64'(PERIOD_MAX)) ? PERIOD_MAX : quotient[PERIOD_W-1:0];
    endfunction

    // One tick of a stepping phase: toggle on zero and reload, else count down
    function automatic logic take_step_tick();
        if (hm_count == 0)
        begin
            hm_count = hm_period;
            return 1'b1;
        end
        hm_count = hm_count - 1'b1;
        return 1'b0;
    endfunction

    // Advance the sequencer by one item and build its result
    function automatic homing_result_t advance_homing(input logic op, input logic sw);
        homing_result_t        r;
        logic [63:0]           product;
        logic [PERIOD_W+1:0]   quad;
        int                    retract_steps;
        r = '0;
        if (op == OP_START)
        begin
            product = 64'(r_max_speed) * 64'(r_steps_per_mm) * 64'(r_speed_percent);
            hm_period = period_for(product / 64'd100);
            hm_dir = r_seek_dir ^ r_invert_dir;
            hm_count = '0;
            hm_phase = CODE_SEEK;
        end
        else
        begin
            case (hm_phase)
                CODE_SEEK:
                begin
                    if (sw)
                    begin
                        hm_dir = ~hm_dir;
                        hm_count = PERIOD_W'(r_dwell);
                        hm_phase = CODE_DWELL1;
                    end
                    else
                        r.step_toggle = take_step_tick();
                end
                CODE_DWELL1:
                begin
                    if (hm_count == 0)
                    begin
                        // backoff runs at a quarter of the seek speed
                        quad = {hm_period, 2'b00};
                        hm_period = (quad > (PERIOD_W+2)'(PERIOD_MAX)) ? PERIOD_MAX
                                                                       : quad[PERIOD_W-1:0];
                        hm_phase = CODE_BACK;
                    end
                    else
                        hm_count = hm_count - 1'b1;
                end
                CODE_BACK:
                begin
                    if (!sw)
                    begin
                        hm_count = PERIOD_W'(r_dwell);
                        hm_phase = CODE_DWELL2;
                    end
                    else
                        r.step_toggle = take_step_tick();
                end
                CODE_DWELL2:
                begin
                    if (hm_count == 0)
                    begin
                        retract_steps = int'(r_retract_mm) * int'(r_steps_per_mm);
                        hm_pos = 0;
                        hm_target = r_seek_dir ? -retract_steps : retract_steps;
                        hm_period = period_for(64'(r_max_speed) * 64'(r_steps_per_mm));
                        hm_phase = CODE_RETRACT;
                    end
                    else
                        hm_count = hm_count - 1'b1;
                end
                CODE_RETRACT:
                begin
                    if (hm_pos == hm_target)
                    begin
                        hm_pos = int'($signed(r_home_mm)) * int'(r_steps_per_mm);
                        hm_phase = CODE_IDLE;
                        r.done_res = 1'b1;
                    end
                    else
                    begin
                        r.step_toggle = take_step_tick();
                        if (r.step_toggle)
                            hm_pos = (hm_pos < hm_target) ? hm_pos + 1 : hm_pos - 1;
                    end
                end
                default:
                    hm_phase = CODE_IDLE;
            endcase
        end
        r.dir_level = hm_dir;
        r.phase = hm_phase;
        r.busy_res = (hm_phase != CODE_IDLE);
        r.position = hm_pos[POS_W-1:0];
        return r;
    endfunction

    task automatic apply_reg_write(input logic [CFG_AW-1:0] index,
                                   input logic [CFG_DW-1:0] value);
        case (index)
            REG_MAX_SPEED:      r_max_speed = value[9:0];
            REG_STEPS_PER_MM:   r_steps_per_mm = value[9:0];
            REG_SPEED_PERCENT:  r_speed_percent = value[6:0];
            REG_SEEK_DIRECTION: r_seek_dir = value[0];
            REG_INVERT_DIR:     r_invert_dir = value[0];
            REG_RETRACT_MM:     r_retract_mm = value[7:0];
            REG_HOME_POS_MM:    r_home_mm = value[15:0];
            REG_DWELL_TICKS:    r_dwell = value[21:0];
            default: ;
        endcase
    endtask

    // Compare one result transaction against the oldest prediction
    task automatic compare_result(input logic [OUT_DW-1:0] data);
        homing_result_t got;
        homing_result_t want;
        got.step_toggle = data[0];
        got.dir_level = data[1];
        got.phase = data[4:2];
        got.busy_res = data[5];
        got.done_res = data[6];
        got.position = data[33:7];
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result %h arrived with nothing expected", data));
            return;
        end
        want = expected_results.pop_front();
        if (got.step_toggle !== want.step_toggle)
            report_mismatch($sformatf("result %0d step_toggle got %b want %b",
                                      result_index, got.step_toggle, want.step_toggle));
        if (got.dir_level !== want.dir_level)
            report_mismatch($sformatf("result %0d dir_level got %b want %b",
                                      result_index, got.dir_level, want.dir_level));
        if (got.phase !== want.phase)
            report_mismatch($sformatf("result %0d phase got %0d want %0d",
                                      result_index, got.phase, want.phase));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("result %0d busy_res got %b want %b",
                                      result_index, got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("result %0d done_res got %b want %b",
                                      result_index, got.done_res, want.done_res));
        if (got.position !== want.position)
            report_mismatch($sformatf("result %0d position got %0d want %0d",
                                      result_index, $signed(got.position),
                                      $signed(want.position)));
        result_index++;
    endtask

    // Results first, then register writes, then new items: a result at this
    // edge always belongs to an item accepted earlier
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_max_speed = 10'd100;
            r_steps_per_mm = 10'd80;
            r_speed_percent = 7'd20;
            r_seek_dir = 1'b0;
            r_invert_dir = 1'b0;
            r_retract_mm = 8'd5;
            r_home_mm = 16'd0;
            r_dwell = 22'd2000000;
            hm_phase = CODE_IDLE;
            hm_count = '0;
            hm_period = '0;
            hm_pos = 0;
            hm_target = 0;
            hm_dir = 1'b0;
            expected_results.delete();
            result_index = 0;
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_addr, cfg_data);
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_homing(s_tuser, s_tdata[0]));
            pending <= expected_results.size();
        end
    end

endmodule

>>> dv/tb_stepper_axis_homing_controller.sv
// ----------------------------------------------------------------------------
// tb_stepper_axis_homing_controller
// Drives the homing controller with a short directed walk through every
// phase, then with random homing runs and noise under nine register setups
// and three flow-control mixes; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_stepper_axis_homing_controller
    import hac_pkg::*;
();

    // Longest quiet stretch of a correct run is a start item's period computation
    // behind a long random stall; this leaves a wide margin over that stretch
    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int DRAIN_CYCLES    = 64;
    localparam int LONG_DWELL      = 12;

    typedef struct packed {
        logic [9:0]  max_speed;
        logic [9:0]  steps_per_mm;
        logic [6:0]  speed_percent;
        logic        seek_dir;
        logic        invert_dir;
        logic [7:0]  retract_mm;
        logic [15:0] home_mm;
        logic [21:0] dwell_ticks;
    } homing_setup_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata = '0;    // [0] home_switch, [7:1] zero
    logic              s_tuser = 1'b0;  // [0] op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;         // [0] step_toggle, [1] dir_level,
                                        // [4:2] phase, [5] busy_res,
                                        // [6] done_res, [33:7] position,
                                        // [39:34] zero
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    int pending;
    int fail_count;
    int src_idle_pct = 19;
    int sink_idle_pct = 84;
    int items_sent = 0;
    int quiet_cycles = 0;
    homing_setup_t cur_setup;

    stepper_axis_homing_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    homing_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #10 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Abort when no transaction moves on any channel for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic homing_setup_t setup_of(input int max_speed, input int steps_per_mm,
                                               input int speed_percent, input bit seek_dir,
                                               input bit invert_dir, input int retract_mm,
                                               input logic [15:0] home_mm,
                                               input int dwell_ticks);
        homing_setup_t s;
        s.max_speed = 10'(max_speed);
        s.steps_per_mm = 10'(steps_per_mm);
        s.speed_percent = 7'(speed_percent);
        s.seek_dir = seek_dir;
        s.invert_dir = invert_dir;
        s.retract_mm = 8'(retract_mm);
        s.home_mm = home_mm;
        s.dwell_ticks = 22'(dwell_ticks);
        return s;
    endfunction

    // Random setup with short dwells and a retract of at most one step
    function automatic homing_setup_t random_setup();
        homing_setup_t s;
        s.max_speed = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(1, 1000));
        s.steps_per_mm = 10'($urandom_range(2, 1000));
        s.retract_mm = 8'd0;
        case ($urandom_range(2))
            0:
            begin
                s.steps_per_mm = 10'd0;
                s.retract_mm = 8'($urandom_range(0, 255));
            end
            1:
            begin
                s.steps_per_mm = 10'd1;
                s.retract_mm = 8'($urandom_range(0, 1));
            end
            default: ;
        endcase
        s.speed_percent = 7'($urandom_range(0, 100));
        s.seek_dir = 1'($urandom_range(0, 1));
        s.invert_dir = 1'($urandom_range(0, 1));
        s.home_mm = 16'($urandom);
        s.dwell_ticks = 22'($urandom_range(0, 8));
        return s;
    endfunction

    // Hold one register write until its handshake; caller drops valid
    task automatic write_reg(input logic [CFG_AW-1:0] index, input logic [CFG_DW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setup(input homing_setup_t s);
        cur_setup = s;
        write_reg(REG_MAX_SPEED, CFG_DW'(s.max_speed));
        write_reg(REG_STEPS_PER_MM, CFG_DW'(s.steps_per_mm));
        write_reg(REG_SPEED_PERCENT, CFG_DW'(s.speed_percent));
        write_reg(REG_SEEK_DIRECTION, CFG_DW'(s.seek_dir));
        write_reg(REG_INVERT_DIR, CFG_DW'(s.invert_dir));
        write_reg(REG_RETRACT_MM, CFG_DW'(s.retract_mm));
        write_reg(REG_HOME_POS_MM, CFG_DW'(s.home_mm));
        write_reg(REG_DWELL_TICKS, CFG_DW'(s.dwell_ticks));
        cfg_valid <= 1'b0;
    endtask

    // Send one item, with a random gap ahead of it
    task automatic send_item(input logic op, input logic sw);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= IN_DW'(sw);
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // One well-formed homing run with random lengths and switch noise
    task automatic run_homing();
        int seek_len;
        int back_len;
        seek_len = $urandom_range(0, 6);
        back_len = $urandom_range(0, 6);
        send_item(OP_START, 1'($urandom_range(0, 1)));
        repeat (seek_len) send_item(OP_TICK, 1'b0);
        // abandon now and then, so the next start hits a busy sequencer
        if ($urandom_range(9) == 0)
            return;
        send_item(OP_TICK, 1'b1);
        if (cur_setup.dwell_ticks > LONG_DWELL)
        begin
            repeat ($urandom_range(1, 4)) send_item(OP_TICK, 1'($urandom_range(0, 1)));
            return;
        end
        // switch level is ignored while dwelling
        repeat (cur_setup.dwell_ticks + 1) send_item(OP_TICK, 1'($urandom_range(0, 1)));
        repeat (back_len) send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        repeat (cur_setup.dwell_ticks + 1) send_item(OP_TICK, 1'($urandom_range(0, 1)));
        // retract of up to one step, then a few idle ticks
        repeat ($urandom_range(2, 5)) send_item(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_item(($urandom_range(3) == 0) ? OP_START : OP_TICK,
                      1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        homing_setup_t setup;
        int goal;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: slow seek, one-step retract towards negative
        apply_setup(setup_of(1000, 1, 100, 1'b1, 1'b0, 1, 16'h8000, 1));
        // idle ticks with the switch open and pressed
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        // start, two seek ticks, then restart while busy
        send_item(OP_START, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_START, 1'b1);
        // one seek step, then the switch closes
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        // dwell, two backoff ticks, switch opens
        repeat (2) send_item(OP_TICK, 1'b0);
        repeat (2) send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        // second dwell, retract step, finish, idle
        repeat (2) send_item(OP_TICK, 1'b1);
        repeat (3) send_item(OP_TICK, 1'b0);

        // Random runs under nine setups and three flow-control mixes
        for (int p = 1; p <= 9; p++)
        begin
            drain_results();
            if (p == 2)
                setup = setup_of(0, 0, 0, 1'b0, 1'b1, 255, 16'h8000, 0);
            else if (p == 5)
                setup = setup_of(1000, 1000, 100, 1'b1, 1'b1, 0, 16'h7FFF, 4194303);
            else
                setup = random_setup();
            apply_setup(setup);
            if (p == 4)
            begin
                src_idle_pct = 84;
                sink_idle_pct <= 19;
            end
            else if (p == 7)
            begin
                src_idle_pct = 0;
                sink_idle_pct <= 0;
            end
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                if ($urandom_range(9) < 8)
                    run_homing();
                else
                    send_noise();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
